### src/rmsef_pkg.sv
// Shared types and constants for the RMS envelope follower.
// Holds the sample and coefficient widths, register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rmsef_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int LEVEL_W     = 24;
  localparam int M_TDATA_W   = 24;
  localparam int COEF_W      = 25;
  localparam int MS_W        = 48;
  localparam int FRAC_W      = 24;
  localparam int MUL_W       = (SAMPLE_BITS > COEF_W) ? SAMPLE_BITS : COEF_W;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SQ_LSH      = (SAMPLE_BITS <= 25) ? (50 - 2 * SAMPLE_BITS) : 0;
  localparam int SQ_RSH      = (SAMPLE_BITS > 25) ? (2 * SAMPLE_BITS - 50) : 0;
  localparam int SQ_W        = PROD_W + SQ_LSH;
  localparam int ACC_W       = 74;
  localparam int ROOT_STEPS  = MS_W / 2;
  localparam int STEP_W      = 5;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [COEF_W-1:0] ONE_Q24 = COEF_W'(25'h1000000);
  localparam logic [COEF_W-1:0] SQUARE_WEIGHT_RST = COEF_W'(16431303);
  localparam logic [COEF_W-1:0] ATTACK_COEFF_RST  = COEF_W'(16707456);
  localparam logic [COEF_W-1:0] RELEASE_COEFF_RST = COEF_W'(16775468);
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  // Register index codes, taken from paddr[3:2].
  localparam logic [1:0] REG_SQUARE_WEIGHT = 2'd0;
  localparam logic [1:0] REG_ATTACK_COEFF  = 2'd1;
  localparam logic [1:0] REG_RELEASE_COEFF = 2'd2;

  // Last step index of each multi-cycle phase.
  localparam logic [STEP_W-1:0] MSQ_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
  localparam logic [STEP_W-1:0] ENV_LAST  = STEP_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MSQ,
    ST_ROOT,
    ST_ENV,
    ST_FINISH
  } state_t;

  function automatic logic [COEF_W-1:0] clamp_coef(input logic [COEF_W-1:0] c);
    return (c > ONE_Q24) ? ONE_Q24 : c;
  endfunction

endpackage

### src/rms_envelope_follower_core.sv
// RMS envelope follower top level: sequencer, shared multiplier and accumulator, bit-serial root.
// Depends on rmsef_pkg.
//
// Usage:
//   Input channel s_*: one signed Q1.23 sample word per transfer in s_tdata.
//   Output channel m_*: one unsigned Q0.24 envelope word per input word in m_tdata.
//   APB port: square_weight at 0x0, attack_coeff at 0x4, release_coeff at 0x8,
//   each 25 bits of Q1.24; values above 1.0 act as 1.0. Write only while idle.
// Timing:
//   A sample runs through one square, four multiply-accumulates for the mean
//   square, 24 root iterations and two multiply-accumulates for the envelope,
//   all on one shared 25x25 multiplier and one 74-bit accumulator.
//   The result is loaded into the output register as the sequencer returns to
//   idle, and no new word is taken before the previous one is finished.
//   s_tready is high only while the sequencer is idle.
// Stalls and reset:
//   A finished result waits in the output register. If the previous word is
//   still not taken when the next result is ready, the sequencer holds in its
//   final state until m_tready frees the register.
//   Synchronous reset clears the mean square and the envelope, loads the
//   register defaults and empties the output register.
`timescale 1ns / 1ps

module rms_envelope_follower_core
  import rmsef_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] sample
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [23:0] level
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  state_t state, state_next;
  logic [STEP_W-1:0] step;

  logic [COEF_W-1:0] square_weight, attack_coeff, release_coeff;
  logic [MS_W-1:0]   mean_square;
  logic [LEVEL_W-1:0] envelope;
  logic [SAMPLE_BITS-1:0] mag;
  logic [MS_W-1:0]   sq;
  logic [ACC_W-1:0]  acc;
  logic [MS_W-1:0]   rem;
  logic [MS_W-1:0]   res;
  logic [MS_W-1:0]   sbit;
  logic [LEVEL_W-1:0] root;
  logic [LEVEL_W-1:0] level;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              acc_init, add_hi, load_out;
  logic [ACC_W-1:0]  addend, acc_sum;
  logic [MS_W-1:0]   ms_sat;
  logic [LEVEL_W-1:0] env_sat;
  logic [SQ_W-1:0]   sq_wide;
  logic [MS_W-1:0]   sq_sat;
  logic [COEF_W-1:0] w_clamped, w_comp, c_clamped, c_comp;
  logic [MS_W:0]     trial;
  logic              cfg_write;
  logic [SAMPLE_BITS-1:0] x_in;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_SQUARE_WEIGHT: prdata = PDATA_W'(square_weight);
      REG_ATTACK_COEFF:  prdata = PDATA_W'(attack_coeff);
      REG_RELEASE_COEFF: prdata = PDATA_W'(release_coeff);
      default:           prdata = '0;
    endcase
  end

  // Coefficient selection: attack when the root climbs above the envelope.
  assign w_clamped = clamp_coef(square_weight);
  assign w_comp    = ONE_Q24 - w_clamped;
  assign c_clamped = clamp_coef((root > envelope) ? attack_coeff : release_coeff);
  assign c_comp    = ONE_Q24 - c_clamped;

  assign x_in = s_tdata[SAMPLE_BITS-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_MSQ;
      ST_MSQ:    if (step == MSQ_LAST) state_next = ST_ROOT;
      ST_ROOT:   if (step == ROOT_LAST) state_next = ST_ENV;
      ST_ENV:    if (step == ENV_LAST) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and accumulator control.
  always_comb begin
    s_tready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    acc_init = 1'b0;
    add_hi   = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SQUARE: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(mag);
      end
      ST_MSQ: begin
        acc_init = (step == '0);
        add_hi   = step[1];
        case (step[1:0])
          2'd0: begin
            mul_a = MUL_W'(mean_square[FRAC_W-1:0]);
            mul_b = MUL_W'(w_comp);
          end
          2'd1: begin
            mul_a = MUL_W'(sq[FRAC_W-1:0]);
            mul_b = MUL_W'(w_clamped);
          end
          2'd2: begin
            mul_a = MUL_W'(mean_square[MS_W-1:FRAC_W]);
            mul_b = MUL_W'(w_comp);
          end
          default: begin
            mul_a = MUL_W'(sq[MS_W-1:FRAC_W]);
            mul_b = MUL_W'(w_clamped);
          end
        endcase
      end
      ST_ENV: begin
        acc_init = (step == '0);
        if (step == '0) begin
          mul_a = MUL_W'(root);
          mul_b = MUL_W'(c_comp);
        end else begin
          mul_a = MUL_W'(envelope);
          mul_b = MUL_W'(c_clamped);
        end
      end
      ST_FINISH: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign addend  = add_hi ? (ACC_W'(prod) << FRAC_W) : ACC_W'(prod);
  assign acc_sum = (acc_init ? ROUND_HALF : acc) + addend;

  assign ms_sat  = (|acc_sum[ACC_W-1:FRAC_W+MS_W]) ? '1 : acc_sum[FRAC_W+MS_W-1:FRAC_W];
  assign env_sat = (|acc_sum[ACC_W-1:FRAC_W+LEVEL_W]) ? '1 : acc_sum[FRAC_W+LEVEL_W-1:FRAC_W];

  // Square aligned to Q0.48; only the most negative sample overflows.
  assign sq_wide = (SQ_W'(prod) << SQ_LSH) >> SQ_RSH;
  assign sq_sat  = (|sq_wide[SQ_W-1:MS_W]) ? '1 : sq_wide[MS_W-1:0];

  assign trial = {1'b0, res} + {1'b0, sbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      square_weight <= SQUARE_WEIGHT_RST;
      attack_coeff  <= ATTACK_COEFF_RST;
      release_coeff <= RELEASE_COEFF_RST;
      mean_square   <= '0;
      envelope      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + STEP_W'(1);
      if (cfg_write) begin
        case (paddr[3:2])
          REG_SQUARE_WEIGHT: square_weight <= pwdata[COEF_W-1:0];
          REG_ATTACK_COEFF:  attack_coeff  <= pwdata[COEF_W-1:0];
          REG_RELEASE_COEFF: release_coeff <= pwdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_MSQ && step == MSQ_LAST) mean_square <= ms_sat;
      if (state == ST_ENV && step == ENV_LAST) envelope <= env_sat;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      mag <= x_in[SAMPLE_BITS-1] ? (~x_in + SAMPLE_BITS'(1)) : x_in;
    end
    if (state == ST_SQUARE) sq <= sq_sat;
    if (state == ST_MSQ || state == ST_ENV) acc <= acc_sum;
    if (state == ST_MSQ && step == MSQ_LAST) begin
      rem  <= ms_sat;
      res  <= '0;
      sbit <= MS_W'(1) << (MS_W - 2);
    end
    // One restoring root iteration per cycle.
    if (state == ST_ROOT) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[MS_W-1:0];
        res <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (state == ST_ROOT && step == ROOT_LAST) begin
      // The final iteration result is formed here; the root always fits in 24 bits.
      if ({1'b0, rem} >= trial) root <= ((res >> 1) + sbit) > MS_W'({LEVEL_W{1'b1}}) ?
                                        '1 : ((res[LEVEL_W:1]) + sbit[LEVEL_W-1:0]);
      else root <= res[LEVEL_W:1];
    end
    if (state == ST_ENV && step == ENV_LAST) level <= env_sat;
    if (load_out) m_tdata <= level;
  end

endmodule

### src/rmsef_checker.sv
// Port-level checker for the RMS envelope follower, with its bind to the top level.
// Depends on rmsef_pkg and rms_envelope_follower_core.
`timescale 1ns / 1ps

module rmsef_checker
  import rmsef_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // A word waiting on a stalled receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset empties the output register and leaves the block ready.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // The sequencer is still busy in the envelope phase of an accepted sample.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##31 !s_tready)
    else $error("input taken before the previous sample finished");

  // A new result only appears as the sequencer leaves its busy phase.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind rms_envelope_follower_core rmsef_checker u_rmsef_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
